// ===== design/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants and controller/datapath interface types for the
// lexicographic permutation generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int LPG_MAX_LEN_DEF = 8;   // default built maximum length
    localparam int LPG_LEN_W       = 4;   // width of the length register
    localparam int LPG_LEN_RESET   = 8;   // length register after reset
    localparam int LPG_WORD_W      = 24;  // packed permutation width
    localparam int LPG_PACK_BITS   = 3;   // bits per packed position
    localparam int LPG_PACK_POS    = LPG_WORD_W / LPG_PACK_BITS;

    // commands from controller to datapath
    typedef struct packed {
        logic load_ident;  // identity into the order, mark started
        logic scan_init;   // clear scan index and pivot flag
        logic scan_step;   // examine one position of the order
        logic swap;        // exchange pivot and partner, set up reversal
        logic rev_rd;      // fetch the low element of a reversal pair
        logic rev_wr;      // exchange the reversal pair
        logic emit;        // load the result registers
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic started;
        logic scan_last;
        logic found;
        logic rev_more;
    } t_status;

endpackage

// ===== design/lpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpg_ctrl
// Sequencer for the permutation generator: input/output handshakes and the
// scan, swap and reversal steps issued to the datapath.
// ----------------------------------------------------------------------------
module lpg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_restart,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  lpg_pkg::t_status i_status,
    output lpg_pkg::t_cmd    o_cmd
);
    import lpg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWAP,
        S_REV_RD,
        S_REV_WR,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_restart || !i_status.started) begin
                        o_cmd.load_ident = 1'b1;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_SWAP: begin
                // no ascent anywhere: last permutation, wrap to identity
                if (i_status.found) begin
                    o_cmd.swap = 1'b1;
                end else begin
                    o_cmd.load_ident = 1'b1;
                end
            end
            S_REV_RD: begin
                o_cmd.rev_rd = i_status.rev_more;
            end
            S_REV_WR: begin
                o_cmd.rev_wr = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_restart || !i_status.started) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_status.scan_last) begin
                        r_state <= S_SWAP;
                    end
                end
                S_SWAP: begin
                    r_state <= i_status.found ? S_REV_RD : S_EMIT;
                end
                S_REV_RD: begin
                    r_state <= i_status.rev_more ? S_REV_WR : S_EMIT;
                end
                S_REV_WR: begin
                    r_state <= S_REV_RD;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("controller stayed idle after taking an item");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result raised outside the emit step");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

endmodule

// ===== design/lpg_datapath.sv =====
// ----------------------------------------------------------------------------
// lpg_datapath
// Holds the current order and the length; scans for pivot and partner,
// swaps them, reverses the suffix and packs the result.
// ----------------------------------------------------------------------------
module lpg_datapath #(
    parameter int MAX_LEN = lpg_pkg::LPG_MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lpg_pkg::LPG_LEN_W-1:0]   i_cfg_wr_data,
    input  lpg_pkg::t_cmd                   i_cmd,
    output lpg_pkg::t_status                o_status,
    output logic [lpg_pkg::LPG_WORD_W-1:0]  o_permutation_word,
    output logic                            o_final_one
);
    import lpg_pkg::*;

    localparam int IW     = $clog2(MAX_LEN);
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int PACK_N = (MAX_LEN < LPG_PACK_POS) ? MAX_LEN : LPG_PACK_POS;

    typedef logic [IW-1:0] t_elem;

    function automatic logic [LW-1:0] eff_len(input logic [LPG_LEN_W-1:0] v);
        int unsigned t;
        t = 32'(v);
        if (t == 0) t = 1;
        if (t > unsigned'(MAX_LEN)) t = unsigned'(MAX_LEN);
        return LW'(t);
    endfunction

    t_elem r_ord [MAX_LEN];
    t_elem n_ord [MAX_LEN];
    logic [LW-1:0] r_len, n_len;
    logic          r_started, n_started;

    t_elem r_idx, n_idx;
    t_elem r_prev, n_prev;
    logic  r_found, n_found;
    t_elem r_p, n_p;
    t_elem r_pval, n_pval;
    t_elem r_q, n_q;
    t_elem r_qval, n_qval;
    t_elem r_lo, n_lo;
    t_elem r_hi, n_hi;
    t_elem r_tmp, n_tmp;
    logic [LPG_WORD_W-1:0] r_word, n_word;
    logic                  r_final, n_final;

    t_elem w_rd_addr;
    t_elem w_rd;

    // single read port into the order
    assign w_rd_addr = i_cmd.rev_wr ? r_hi : (i_cmd.rev_rd ? r_lo : r_idx);
    assign w_rd      = r_ord[w_rd_addr];

    assign o_status.started   = r_started;
    assign o_status.scan_last = (LW'(r_idx) == r_len - 1'b1);
    assign o_status.found     = r_found;
    assign o_status.rev_more  = (r_lo < r_hi);

    assign o_permutation_word = r_word;
    assign o_final_one        = r_final;

    always_comb begin
        n_ord     = r_ord;
        n_len     = r_len;
        n_started = r_started;
        n_idx     = r_idx;
        n_prev    = r_prev;
        n_found   = r_found;
        n_p       = r_p;
        n_pval    = r_pval;
        n_q       = r_q;
        n_qval    = r_qval;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_tmp     = r_tmp;
        n_word    = r_word;
        n_final   = r_final;

        if (i_cfg_wr_en) begin
            n_len     = eff_len(i_cfg_wr_data);
            n_started = 1'b0;
            for (int k = 0; k < MAX_LEN; k++) n_ord[k] = IW'(k);
        end

        if (i_cmd.load_ident) begin
            n_started = 1'b1;
            for (int k = 0; k < MAX_LEN; k++) n_ord[k] = IW'(k);
        end

        if (i_cmd.scan_init) begin
            n_idx   = '0;
            n_found = 1'b0;
        end

        // Track the rightmost ascent as pivot; the suffix after it is
        // descending, so the partner is the last element above the pivot.
        if (i_cmd.scan_step) begin
            n_prev = w_rd;
            n_idx  = r_idx + 1'b1;
            if (r_idx != '0 && r_prev < w_rd) begin
                n_found = 1'b1;
                n_p     = r_idx - 1'b1;
                n_pval  = r_prev;
                n_q     = r_idx;
                n_qval  = w_rd;
            end else if (r_found && w_rd > r_pval) begin
                n_q    = r_idx;
                n_qval = w_rd;
            end
        end

        if (i_cmd.swap) begin
            n_ord[r_p] = r_qval;
            n_ord[r_q] = r_pval;
            n_lo       = r_p + 1'b1;
            n_hi       = IW'(r_len - 1'b1);
        end

        if (i_cmd.rev_rd) begin
            n_tmp = w_rd;
        end

        if (i_cmd.rev_wr) begin
            n_ord[r_lo] = w_rd;
            n_ord[r_hi] = r_tmp;
            n_lo        = r_lo + 1'b1;
            n_hi        = r_hi - 1'b1;
        end

        if (i_cmd.emit) begin
            n_word  = '0;
            n_final = 1'b1;
            for (int k = 0; k < PACK_N; k++) begin
                if (LW'(k) < r_len) begin
                    n_word[LPG_PACK_BITS*k +: LPG_PACK_BITS] = LPG_PACK_BITS'(r_ord[k]);
                end
            end
            for (int k = 0; k < MAX_LEN - 1; k++) begin
                if (LW'(k + 1) < r_len && r_ord[k] < r_ord[k+1]) begin
                    n_final = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= eff_len(LPG_LEN_W'(LPG_LEN_RESET));
            r_started <= 1'b0;
            for (int k = 0; k < MAX_LEN; k++) r_ord[k] <= IW'(k);
        end else begin
            r_len     <= n_len;
            r_started <= n_started;
            r_ord     <= n_ord;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_found <= n_found;
        r_p     <= n_p;
        r_pval  <= n_pval;
        r_q     <= n_q;
        r_qval  <= n_qval;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_tmp   <= n_tmp;
        r_word  <= n_word;
        r_final <= n_final;
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (LW'(r_idx) < r_len))
        else $error("scan ran past the configured length");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.swap |-> (r_found && r_q > r_p))
        else $error("swap without a valid pivot and partner");

    a_rev_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rev_wr |-> (r_lo < r_hi))
        else $error("reversal exchange on a crossed pair");

endmodule

// ===== design/lexicographic_permutation_generator.sv =====
// ----------------------------------------------------------------------------
// lexicographic_permutation_generator
// Steps through every permutation of 0..n-1 in lexicographic order, one
// permutation per request item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_restart. restart=1 gives the
//   identity; restart=0 gives the permutation after the current one. The
//   first item after reset or after a length write always gives the identity.
//   Output channel: o_out_valid / i_out_stall with o_permutation_word (3 bits
//   per position, position 0 lowest, positions beyond n zero) and
//   o_final_one (set on the descending permutation; the next item wraps).
//   Length: i_cfg_wr_en / i_cfg_wr_data; the user must write it only while
//   idle, as the block does not enforce it. 0 acts as 1, values above
//   MAX_LEN act as MAX_LEN. Reset value 8. An identity item loads the
//   identity, then the output register. An advance item scans the n
//   positions, swaps pivot and partner, then alternates a read and an
//   exchange per suffix pair, with a last check, and loads the output. The
//   wrap after the descending permutation scans, loads the identity in the
//   swap step and loads the output. One item at a time; the next is taken at
//   the edge its predecessor's result can first leave. A stalled result holds
//   the block in its output step and stops input until the register frees.
//   Reset: length 8, identity order, output empty.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator #(
    parameter int MAX_LEN = lpg_pkg::LPG_MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lpg_pkg::LPG_LEN_W-1:0]   i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lpg_pkg::LPG_WORD_W-1:0]  o_permutation_word,
    output logic                            o_final_one
);
    import lpg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    lpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lpg_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_permutation_word (o_permutation_word),
        .o_final_one        (o_final_one)
    );

endmodule
